// ===== hdl/wsd_pkg.sv =====
// shared types and constants of the websocket deframer
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;
    localparam logic [2:0] KEY_BYTES  = 3'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [3:0] frame_opcode;
        logic       final_fragment;
        logic       last_of_frame;
        logic       send_reply;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/wsd_parser.sv =====
// header parser, length and key tracking, payload unmasking
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_buffer_start,
    output wsd_pkg::t_result       o_result,
    output logic                   o_result_valid
);

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_PAY  = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase, cur_phase;
    logic [2:0]  r_ext_left, n_ext_left;
    logic [2:0]  r_key_left, n_key_left;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_key_idx, n_key_idx;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin, n_fin;
    logic        r_masked, n_masked;

    logic [7:0]  key_byte;
    logic [63:0] rem_dec;
    logic [2:0]  key_left_dec;
    logic        emit, emit_valid, emit_last;
    logic [7:0]  emit_byte;

    assign cur_phase    = i_buffer_start ? PH_HDR0 : r_phase;
    assign rem_dec      = r_rem - 64'd1;
    assign key_left_dec = (r_key_left != 3'd0) ? r_key_left - 3'd1 : r_key_left;

    always_comb begin
        unique case (r_key_idx)
            2'd0: key_byte = r_key[31:24];
            2'd1: key_byte = r_key[23:16];
            2'd2: key_byte = r_key[15:8];
            2'd3: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase    = cur_phase;
        n_ext_left = r_ext_left;
        n_key_left = r_key_left;
        n_rem      = r_rem;
        n_key      = r_key;
        n_key_idx  = r_key_idx;
        n_opcode   = r_opcode;
        n_fin      = r_fin;
        n_masked   = r_masked;
        emit       = 1'b0;
        emit_valid = 1'b0;
        emit_last  = 1'b0;
        emit_byte  = 8'd0;
        unique case (cur_phase)
            PH_HDR1: begin
                n_masked = i_data_byte[7];
                n_rem    = 64'd0;
                if (i_data_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
                    n_ext_left = wsd_pkg::EXT16_LEFT;
                    n_phase    = PH_EXT;
                end else if (i_data_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
                    n_ext_left = wsd_pkg::EXT64_LEFT;
                    n_phase    = PH_EXT;
                end else begin
                    n_rem = {57'd0, i_data_byte[6:0]};
                    if (i_data_byte[7]) begin
                        n_key      = 32'd0;
                        n_key_left = wsd_pkg::KEY_BYTES;
                        n_phase    = PH_KEY;
                    end else begin
                        n_key_idx = 2'd0;
                        if (i_data_byte[6:0] == 7'd0) begin
                            n_phase   = PH_HDR0;
                            emit      = 1'b1;
                            emit_last = 1'b1;
                        end else begin
                            n_phase = PH_PAY;
                        end
                    end
                end
            end
            PH_EXT: begin
                n_rem = {r_rem[55:0], i_data_byte};
                if (r_ext_left == 3'd0) begin
                    if (r_masked) begin
                        n_key      = 32'd0;
                        n_key_left = wsd_pkg::KEY_BYTES;
                        n_phase    = PH_KEY;
                    end else begin
                        n_key_idx = 2'd0;
                        if ({r_rem[55:0], i_data_byte} == 64'd0) begin
                            n_phase   = PH_HDR0;
                            emit      = 1'b1;
                            emit_last = 1'b1;
                        end else begin
                            n_phase = PH_PAY;
                        end
                    end
                end else begin
                    n_ext_left = r_ext_left - 3'd1;
                end
            end
            PH_KEY: begin
                n_key      = {r_key[23:0], i_data_byte};
                n_key_left = key_left_dec;
                if (key_left_dec == 3'd0) begin
                    n_key_idx = 2'd0;
                    if (r_rem == 64'd0) begin
                        n_phase   = PH_HDR0;
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end else begin
                        n_phase = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                n_key_idx  = r_key_idx + 2'd1;
                n_rem      = rem_dec;
                emit       = 1'b1;
                emit_valid = 1'b1;
                emit_last  = (rem_dec == 64'd0);
                emit_byte  = r_masked ? (i_data_byte ^ key_byte) : i_data_byte;
                if (rem_dec == 64'd0) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                // header byte zero; unused codes land here too
                n_fin    = i_data_byte[7];
                n_opcode = i_data_byte[3:0];
                n_phase  = PH_HDR1;
            end
        endcase
    end

    assign o_result_valid           = i_accept & emit;
    assign o_result.payload_byte    = emit_byte;
    assign o_result.payload_valid   = emit_valid;
    assign o_result.frame_opcode    = r_opcode;
    assign o_result.final_fragment  = r_fin;
    assign o_result.last_of_frame   = emit_last;
    assign o_result.send_reply      = emit_last & (r_opcode == wsd_pkg::OPC_TEXT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_ext_left <= 3'd0;
            r_key_left <= 3'd0;
            r_rem      <= 64'd0;
            r_key      <= 32'd0;
            r_key_idx  <= 2'd0;
            r_opcode   <= 4'd0;
            r_fin      <= 1'b0;
            r_masked   <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_ext_left <= n_ext_left;
            r_key_left <= n_key_left;
            r_rem      <= n_rem;
            r_key      <= n_key;
            r_key_idx  <= n_key_idx;
            r_opcode   <= n_opcode;
            r_fin      <= n_fin;
            r_masked   <= n_masked;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wsd_out_buf.sv =====
// result register with one skid entry
`timescale 1ns / 1ps
`default_nettype none

module wsd_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire wsd_pkg::t_result  i_result,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output wsd_pkg::t_result       o_result
);

    logic             r_out_valid, r_skid_valid;
    wsd_pkg::t_result r_out, r_skid;
    logic             take;

    assign take     = r_out_valid & ~i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || take) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out       <= i_result;
                    r_out_valid <= i_push;
                end
            end else if (i_push) begin
                r_skid       <= i_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/websocket_frame_deframer.sv =====
// top level of the websocket frame deframer and unmasker
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  bytes   | in        | i_valid / o_stall  | i_data_byte, i_buffer_start
//  results | out       | o_valid / i_stall  | o_payload_byte .. o_send_reply
//
// one byte per cycle while o_stall is low; each accepted byte updates parser state
// and its result, if any, is registered in the result register, or the skid if held
// the 64-bit remaining-length decrement and zero test set the cycle's logic depth
// reset is synchronous and active low; it returns the parser to the first header byte
// a stalled result moves into a one-entry skid; o_stall rises only while the skid
// holds a result, so input keeps flowing until the skid fills
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_buffer_start,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_payload_byte,
    output logic            o_payload_valid,
    output logic [3:0]      o_frame_opcode,
    output logic            o_final_fragment,
    output logic            o_last_of_frame,
    output logic            o_send_reply
);

    logic             in_accept;
    logic             res_valid;
    logic             buf_full;
    wsd_pkg::t_result res;
    wsd_pkg::t_result out_res;

    // input is taken whenever the skid entry is free
    assign o_stall   = buf_full;
    assign in_accept = i_valid & ~buf_full;

    wsd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_data_byte    (i_data_byte),
        .i_buffer_start (i_buffer_start),
        .o_result       (res),
        .o_result_valid (res_valid)
    );

    wsd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_valid),
        .i_result (res),
        .o_full   (buf_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_res)
    );

    assign o_payload_byte   = out_res.payload_byte;
    assign o_payload_valid  = out_res.payload_valid;
    assign o_frame_opcode   = out_res.frame_opcode;
    assign o_final_fragment = out_res.final_fragment;
    assign o_last_of_frame  = out_res.last_of_frame;
    assign o_send_reply     = out_res.send_reply;

    // skid only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid holds a result while the result register is empty");

    // reply request only on the closing result of a frame
    a_reply_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_send_reply) |-> o_last_of_frame)
        else $error("reply request away from end of frame");

    // a marker without payload closes an empty frame and carries a zero byte
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_payload_valid) |-> (o_last_of_frame && o_payload_byte == 8'd0))
        else $error("payload-less result is not an empty-frame marker");

endmodule

`default_nettype wire
